// ===== rtl/core/ppp_pkg.sv =====
// Shared types, constants and helpers for the point projection block.
`timescale 1ns / 1ps
package ppp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ADDR_W    = 5;
	localparam int MAT_DEPTH = 32;
	localparam int ACC_W     = 66 - FRAC_BITS;
	localparam int DIV_N     = 32 + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_N);
	localparam int SAT_W     = (DIV_N > 48) ? DIV_N : 48;
	localparam int NDC_W     = 49;
	localparam int NP_W      = NDC_W + 1;
	localparam int MP_W      = NP_W + 17;
	localparam int WIDE_W    = MP_W + 1;

	localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;
	localparam logic signed [63:0] RND64 = (64'sd1 <<< FRAC_BITS) - 64'sd1;
	localparam logic [SAT_W-1:0] NDC_LIMIT = SAT_W'(1) << 47;

	localparam logic [1:0] OP_LOAD_PROJ = 2'd0;
	localparam logic [1:0] OP_LOAD_MV   = 2'd1;
	localparam logic [1:0] OP_PROJECT   = 2'd2;

	localparam logic [7:0] REG_VP_LEFT   = 8'd0;
	localparam logic [7:0] REG_VP_BOTTOM = 8'd1;
	localparam logic [7:0] REG_VP_WIDTH  = 8'd2;
	localparam logic [7:0] REG_VP_HEIGHT = 8'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         idx;
		logic signed [31:0] value;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} item_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] bottom;
		logic [15:0] width;
		logic [15:0] height;
	} vp_t;

	typedef struct packed {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wd;
		logic               wzero;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [NDC_W-1:0]  quot;
	} div_rsp_t;

	function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic [31:0] r;
		if ((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]))
			r = v[31:0];
		else if (v[WIDE_W-1])
			r = 32'h8000_0000;
		else
			r = 32'h7fff_ffff;
		return r;
	endfunction

endpackage

// ===== rtl/core/perspective_project_point.sv =====
// Top level of the point projection block: ports, viewport registers, output register.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op; tdata: index, value, x, y, z
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: w_was_zero; tdata: x, y, depth
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data (viewport registers)
//
// A load item is written to the store in the cycle it is accepted. A project item
// (Q16.16 values) reads the 32 matrix words from memory through one 32x32
// multiplier, then makes three passes of the bit-serial divider, which sets most
// of its run time, then a short mapping tail; a zero w skips both and gives zeros.
// Reset (arst_n low) returns both matrices to identity through per-entry valid
// bits and the viewport to 0, 0, 640, 480. A stalled output holds its result
// while the block goes on with the next item; it waits only to push another.
module perspective_project_point import ppp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [3:0] element_index, [35:4] element_value, [67:36] point_x,
	// [99:68] point_y, [131:100] point_z, [135:132] zero
	input  logic [135:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] window_x, [63:32] window_y, [95:64] window_depth
	output logic [95:0]  m_axis_tdata,
	// [0] w_was_zero
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	vp_t               vp_q;
	item_t             item;
	result_t           res;
	mem_wr_t           mem_wr;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              res_push;
	logic              out_free;
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [31:0]       mem_rd_data;
	logic              out_valid_q;
	result_t           out_q;

	assign item.op    = s_axis_tuser;
	assign item.idx   = s_axis_tdata[3:0];
	assign item.value = s_axis_tdata[35:4];
	assign item.px    = s_axis_tdata[67:36];
	assign item.py    = s_axis_tdata[99:68];
	assign item.pz    = s_axis_tdata[131:100];

	// viewport registers; writes beyond the list drop silently
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q.left   <= 16'd0;
			vp_q.bottom <= 16'd0;
			vp_q.width  <= 16'd640;
			vp_q.height <= 16'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VP_LEFT:   vp_q.left   <= cfg_data;
				REG_VP_BOTTOM: vp_q.bottom <= cfg_data;
				REG_VP_WIDTH:  vp_q.width  <= cfg_data;
				REG_VP_HEIGHT: vp_q.height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ppp_mat_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	ppp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ppp_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.item        (item),
		.vp          (vp_q),
		.out_free    (out_free),
		.res_push    (res_push),
		.res         (res),
		.mem_wr      (mem_wr),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	// output register: free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.wd, out_q.wy, out_q.wx};
	assign m_axis_tuser  = out_q.wzero;

endmodule

// ===== rtl/core/ppp_mat_store.sv =====
// Matrix store: both 4x4 matrices in one synchronous memory, identity after reset.
`timescale 1ns / 1ps
module ppp_mat_store import ppp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_wr_t           wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0]          mem [MAT_DEPTH];
	logic [MAT_DEPTH-1:0] valid_q;
	logic [31:0]          data_s1;
	logic                 vld_s1;
	logic                 diag_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			diag_s1 <= (rd_addr[1:0] == rd_addr[3:2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// unwritten entries read as identity
	assign rd_data = vld_s1 ? data_s1 : (diag_s1 ? ONE_FX : 32'd0);

endmodule

// ===== rtl/core/ppp_div.sv =====
// Bit-serial signed divider producing clip * 2^FRAC_BITS / w, saturated.
`timescale 1ns / 1ps
module ppp_div import ppp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIV_N-1:0]        num_q;
	logic [DIV_N-1:0]        quo_q;
	logic [31:0]             rem_q;
	logic [31:0]             den_q;
	logic                    neg_q;
	logic signed [NDC_W-1:0] quot_q;

	logic [32:0]      trial;
	logic             qbit;
	logic [31:0]      rem_n;
	logic [DIV_N-1:0] quo_n;
	logic [SAT_W-1:0] mag;
	logic [NDC_W-1:0] mag_c;

	always_comb begin
		trial = {rem_q, num_q[DIV_N-1]};
		qbit  = (trial >= {1'b0, den_q});
		rem_n = qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
		quo_n = {quo_q[DIV_N-2:0], qbit};
		mag   = SAT_W'(quo_n);
		mag_c = (mag > NDC_LIMIT) ? NDC_W'(NDC_LIMIT) : NDC_W'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_N - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= {(req.num[31] ? 32'(-req.num) : req.num), {FRAC_BITS{1'b0}}};
			den_q <= req.den[31] ? 32'(-req.den) : req.den;
			neg_q <= req.num[31] ^ req.den[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (cnt_q == '0) begin
				quot_q <= neg_q ? NDC_W'(-mag_c) : mag_c;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== rtl/core/ppp_engine.sv =====
// Sequencer: matrix multiply-accumulate, division and viewport mapping.
`timescale 1ns / 1ps
module ppp_engine import ppp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             item,
	input  vp_t               vp,
	input  logic              out_free,
	output logic              res_push,
	output result_t           res,
	output mem_wr_t           mem_wr,
	output logic              mem_rd_en,
	output logic [ADDR_W-1:0] mem_rd_addr,
	input  logic [31:0]       mem_rd_data,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       k_q;
	logic [1:0]              axis_q;
	logic                    started_q;
	logic signed [31:0]      pt_q   [3];
	logic signed [31:0]      eye_q  [4];
	logic signed [31:0]      clip_q [4];
	logic signed [NDC_W-1:0] ndc_q  [3];
	logic signed [31:0]      win_q  [3];
	logic                    wzero_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [MP_W-1:0]  mprod_q;

	logic                    valid_s1, valid_s2;
	logic [1:0]              col_s1, col_s2, row_s1, row_s2;
	logic                    pass_s1, pass_s2;
	logic signed [63:0]      prod_s2;

	logic                    accept;
	logic signed [31:0]      opnd;
	logic signed [63:0]      trunc_v;
	logic signed [ACC_W-1:0] term, sum;
	logic [15:0]             size_sel, org_sel;
	logic signed [NP_W-1:0]  np;
	logic signed [MP_W-1:0]  half;
	logic signed [WIDE_W-1:0] wide_sum;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign mem_wr.en   = accept && (item.op == OP_LOAD_PROJ || item.op == OP_LOAD_MV);
	assign mem_wr.addr = {item.op == OP_LOAD_PROJ, item.idx};
	assign mem_wr.data = item.value;

	// modelview sits in the low half, projection in the high half
	assign mem_rd_en   = (state_q == ST_MAC);
	assign mem_rd_addr = k_q;

	assign div_req.start = (state_q == ST_DIV) && !started_q && !div_rsp.busy;
	assign div_req.num   = clip_q[axis_q];
	assign div_req.den   = clip_q[3];

	assign res_push = (state_q == ST_OUT) && out_free;
	assign res.wx    = win_q[0];
	assign res.wy    = win_q[1];
	assign res.wd    = win_q[2];
	assign res.wzero = wzero_q;

	always_comb begin
		if (pass_s1)
			opnd = eye_q[col_s1];
		else if (col_s1 == 2'd3)
			opnd = ONE_FX;
		else
			opnd = pt_q[col_s1];
		trunc_v = (prod_s2 + (prod_s2[63] ? RND64 : 64'sd0)) >>> FRAC_BITS;
		term    = trunc_v[ACC_W-1:0];
		sum     = ((col_s2 == 2'd0) ? ACC_W'(0) : acc_q) + term;
		case (axis_q)
			2'd0: begin
				size_sel = vp.width;
				org_sel  = vp.left;
			end
			2'd1: begin
				size_sel = vp.height;
				org_sel  = vp.bottom;
			end
			default: begin
				size_sel = 16'd1;
				org_sel  = 16'd0;
			end
		endcase
		np       = NP_W'(ndc_q[axis_q < 2'd3 ? axis_q : 2'd0]) + NP_W'(ONE_FX);
		half     = (mprod_q + (mprod_q[MP_W-1] ? MP_W'(1) : MP_W'(0))) >>> 1;
		wide_sum = WIDE_W'(half) + (WIDE_W'(org_sel) <<< FRAC_BITS);
	end

	// multiply-accumulate pipeline: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_MAC);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1  <= k_q[1:0];
		row_s1  <= k_q[3:2];
		pass_s1 <= k_q[4];
		col_s2  <= col_s1;
		row_s2  <= row_s1;
		pass_s2 <= pass_s1;
		prod_s2 <= 64'(signed'(mem_rd_data)) * 64'(opnd);
		if (valid_s2) begin
			acc_q <= sum;
			if (col_s2 == 2'd3) begin
				if (pass_s2)
					clip_q[row_s2] <= sat32(WIDE_W'(sum));
				else
					eye_q[row_s2] <= sat32(WIDE_W'(sum));
			end
		end
		if (accept && item.op == OP_PROJECT) begin
			pt_q[0] <= item.px;
			pt_q[1] <= item.py;
			pt_q[2] <= item.pz;
		end
		if (div_rsp.done) begin
			ndc_q[axis_q] <= div_rsp.quot;
		end
		if (state_q == ST_MUL) begin
			mprod_q <= MP_W'(signed'({1'b0, size_sel})) * MP_W'(np);
		end
		if (state_q == ST_ADD) begin
			win_q[axis_q] <= sat32(wide_sum);
		end
		if (state_q == ST_DRAIN && !valid_s1 && !valid_s2 && clip_q[3] == 32'sd0) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			axis_q    <= '0;
			started_q <= 1'b0;
			wzero_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && item.op == OP_PROJECT) begin
						k_q     <= '0;
						wzero_q <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == ADDR_W'(MAT_DEPTH - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						axis_q <= '0;
						if (clip_q[3] == 32'sd0) begin
							wzero_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_req.start)
						started_q <= 1'b1;
					if (div_rsp.done) begin
						started_q <= 1'b0;
						if (axis_q == 2'd2) begin
							axis_q  <= '0;
							state_q <= ST_MUL;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (axis_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> state_q == ST_IDLE)
		else $error("matrix write outside idle");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> out_free)
		else $error("result pushed into a full output register");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy && clip_q[3] != 32'sd0)
		else $error("divider started while busy or with zero w");
	a_drain_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !valid_s1 && !valid_s2)
		else $error("multiply pipeline active during division");
`endif

endmodule
